### design/mrbd_pkg.sv
// shared types for the marker run-length block decoder
// no dependencies; imported by mrbd_parser and marker_rle_block_decoder
`timescale 1ns / 1ps
`default_nettype none

package mrbd_pkg;

    typedef enum logic [3:0] {
        PH_CNT_LO   = 4'd0,
        PH_CNT_HI   = 4'd1,
        PH_PSZ_LO   = 4'd2,
        PH_PSZ_HI   = 4'd3,
        PH_USZ_LO   = 4'd4,
        PH_USZ_HI   = 4'd5,
        PH_MARKER   = 4'd6,
        PH_DATA     = 4'd7,
        PH_LEN8     = 4'd8,
        PH_LEN16_LO = 4'd9,
        PH_LEN16_HI = 4'd10,
        PH_RUNVAL   = 4'd11,
        PH_DONE     = 4'd12
    } t_phase;

    typedef struct packed {
        logic        valid;
        logic [7:0]  value;
        logic [15:0] count;
        logic        block_end;
        logic        size_error;
        logic        image_done;
    } t_result;

endpackage

`default_nettype wire

### design/mrbd_parser.sv
// byte parser: block header fields, marker runs and block fill accounting
// depends on mrbd_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrbd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    output mrbd_pkg::t_result    o_result
);
    import mrbd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [15:0] r_blocks_left, n_blocks_left;
    logic [15:0] r_block_size, n_block_size;
    logic [16:0] r_block_filled, n_block_filled;
    logic [7:0]  r_marker, n_marker;
    logic [15:0] r_run_length, n_run_length;
    logic [7:0]  r_low_hold, n_low_hold;

    logic        emit;
    logic [15:0] emit_count;
    logic [16:0] filled_sum;
    logic [15:0] blocks_dec;
    logic        reach;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_CNT_LO;
            r_blocks_left  <= '0;
            r_block_size   <= '0;
            r_block_filled <= '0;
            r_marker       <= '0;
            r_run_length   <= '0;
            r_low_hold     <= '0;
        end else if (i_step) begin
            r_phase        <= n_phase;
            r_blocks_left  <= n_blocks_left;
            r_block_size   <= n_block_size;
            r_block_filled <= n_block_filled;
            r_marker       <= n_marker;
            r_run_length   <= n_run_length;
            r_low_hold     <= n_low_hold;
        end
    end

    // a literal counts once, a run counts its length
    assign emit_count = (r_phase == PH_RUNVAL) ? r_run_length : 16'd1;
    assign filled_sum = r_block_filled + {1'b0, emit_count};
    assign reach      = (filled_sum >= {1'b0, r_block_size});
    assign blocks_dec = r_blocks_left - 16'd1;

    always_comb begin
        n_phase        = r_phase;
        n_blocks_left  = r_blocks_left;
        n_block_size   = r_block_size;
        n_block_filled = r_block_filled;
        n_marker       = r_marker;
        n_run_length   = r_run_length;
        n_low_hold     = r_low_hold;
        emit           = 1'b0;

        unique case (r_phase)
            PH_CNT_LO: begin
                n_low_hold = i_byte;
                n_phase    = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                n_blocks_left = {i_byte, r_low_hold};
                n_phase       = ({i_byte, r_low_hold} == 16'd0) ? PH_DONE : PH_PSZ_LO;
            end
            PH_PSZ_LO: n_phase = PH_PSZ_HI;
            PH_PSZ_HI: n_phase = PH_USZ_LO;
            PH_USZ_LO: begin
                n_low_hold = i_byte;
                n_phase    = PH_USZ_HI;
            end
            PH_USZ_HI: begin
                n_block_size = {i_byte, r_low_hold};
                n_phase      = PH_MARKER;
            end
            PH_MARKER: begin
                n_marker       = i_byte;
                n_block_filled = '0;
                n_phase        = PH_DATA;
            end
            PH_DATA: begin
                if (i_byte == r_marker) begin
                    n_phase = PH_LEN8;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_LEN8: begin
                if (i_byte == 8'd0) begin
                    n_phase = PH_LEN16_LO;
                end else begin
                    n_run_length = {8'd0, i_byte};
                    n_phase      = PH_RUNVAL;
                end
            end
            PH_LEN16_LO: begin
                n_low_hold = i_byte;
                n_phase    = PH_LEN16_HI;
            end
            PH_LEN16_HI: begin
                n_run_length = {i_byte, r_low_hold};
                n_phase      = PH_RUNVAL;
            end
            PH_RUNVAL: begin
                if (r_run_length == 16'd0) begin
                    n_phase = PH_DATA;
                end else begin
                    emit = 1'b1;
                end
            end
            default: n_phase = r_phase;
        endcase

        if (emit) begin
            n_block_filled = filled_sum;
            if (reach) begin
                n_blocks_left = blocks_dec;
                n_phase       = (blocks_dec == 16'd0) ? PH_DONE : PH_PSZ_LO;
            end else begin
                n_phase = PH_DATA;
            end
        end
    end

    always_comb begin
        o_result.valid      = i_step && emit;
        o_result.value      = i_byte;
        o_result.count      = emit_count;
        o_result.block_end  = reach;
        o_result.size_error = reach && (filled_sum != {1'b0, r_block_size});
        o_result.image_done = reach && (blocks_dec == 16'd0);
    end

`ifndef SYNTHESIS
    a_err_needs_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.size_error |-> o_result.block_end)
        else $error("size error without block end");

    a_done_parks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.image_done |=> r_phase == PH_DONE)
        else $error("image done but parser not parked");

    a_emit_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (r_phase == PH_DATA || r_phase == PH_RUNVAL))
        else $error("result from a header phase");

    a_end_leaves_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.block_end && !o_result.image_done
        |=> r_phase == PH_PSZ_LO)
        else $error("block end did not return to header");
`endif

endmodule

`default_nettype wire

### design/marker_rle_block_decoder.sv
// Marker run-length block decoder: takes the packed pixel stream one byte per
// transaction on i_in_valid/o_in_ready/i_in_byte and gives value/count pairs
// on o_out_valid/i_out_ready with block_end, size_error and image_done flags.
// Each accepted byte sits in an input register until the parser takes it,
// and any result lands in the output register that drives o_out_valid.
// One byte is taken per cycle while the receiver keeps up; the single
// output register sets that, since parsing advances only when the output
// register is empty or being emptied in the same cycle.
// When the receiver stalls with a result waiting, an empty input register
// still takes one more byte, then o_in_ready drops until the result is taken.
// Header, length and marker bytes give no result.
// Reset (i_rst_n low, synchronous) empties both registers and returns the
// parser to the block count; after the last block, bytes are taken and
// ignored until the next reset.
// depends on mrbd_pkg and mrbd_parser
`timescale 1ns / 1ps
`default_nettype none

module marker_rle_block_decoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_value,
    output logic [15:0]      o_out_count,
    output logic             o_block_end,
    output logic             o_size_error,
    output logic             o_image_done
);
    import mrbd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_result    r_out;
    t_result    parse_res;
    logic       advance;

    // the parser moves only when the output slot can take a result
    assign advance    = r_in_valid && (!r_out.valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    mrbd_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .o_result (parse_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (!r_out.valid || i_out_ready) begin
            r_out.valid <= parse_res.valid;
        end
        if (parse_res.valid && (!r_out.valid || i_out_ready)) begin
            r_out.value      <= parse_res.value;
            r_out.count      <= parse_res.count;
            r_out.block_end  <= parse_res.block_end;
            r_out.size_error <= parse_res.size_error;
            r_out.image_done <= parse_res.image_done;
        end
    end

    assign o_out_valid  = r_out.valid;
    assign o_out_value  = r_out.value;
    assign o_out_count  = r_out.count;
    assign o_block_end  = r_out.block_end;
    assign o_size_error = r_out.size_error;
    assign o_image_done = r_out.image_done;

endmodule

`default_nettype wire

### tb/sv/marker_rle_block_decoder_tb.sv
// self-checking testbench for marker_rle_block_decoder: a byte-level parser model
// predicts every value/count pair; depends on mrbd_pkg and the decoder rtl
`timescale 1ns / 1ps

import mrbd_pkg::*;

class pair_scoreboard;
    t_phase      phase;
    logic [15:0] blocks_left;
    logic [15:0] block_size;
    logic [16:0] filled;
    logic [7:0]  marker;
    logic [15:0] run_len;
    logic [7:0]  hold;
    t_result     pairs_due[$];
    int          errors;
    int          pairs_checked;
    int          blocks_closed;
    int          overshoots;
    int          images_done;

    function new();
        phase       = PH_CNT_LO;
        blocks_left = '0;
        block_size  = '0;
        filled      = '0;
        marker      = '0;
        run_len     = '0;
        hold        = '0;
    endfunction

    function bit close_pair(input logic [7:0] value, input logic [15:0] count,
                            output t_result r);
        r = '0;
        r.valid = 1'b1;
        r.value = value;
        r.count = count;
        filled  = filled + {1'b0, count};
        if (filled >= {1'b0, block_size}) begin
            r.block_end  = 1'b1;
            r.size_error = (filled > {1'b0, block_size});
            blocks_left  = blocks_left - 16'd1;
            if (blocks_left == 16'd0) begin
                r.image_done = 1'b1;
                phase        = PH_DONE;
            end else begin
                phase = PH_PSZ_LO;
            end
        end else begin
            phase = PH_DATA;
        end
        return 1'b1;
    endfunction

    // one byte through the parser; returns 1 when it completes a pair
    function bit parse_byte(input logic [7:0] b, output t_result r);
        r = '0;
        case (phase)
            PH_CNT_LO: begin
                hold  = b;
                phase = PH_CNT_HI;
            end
            PH_CNT_HI: begin
                blocks_left = {b, hold};
                phase = (blocks_left == 16'd0) ? PH_DONE : PH_PSZ_LO;
            end
            PH_PSZ_LO: phase = PH_PSZ_HI;
            PH_PSZ_HI: phase = PH_USZ_LO;
            PH_USZ_LO: begin
                hold  = b;
                phase = PH_USZ_HI;
            end
            PH_USZ_HI: begin
                block_size = {b, hold};
                phase      = PH_MARKER;
            end
            PH_MARKER: begin
                marker = b;
                filled = '0;
                phase  = PH_DATA;
            end
            PH_DATA: begin
                if (b == marker) begin
                    phase = PH_LEN8;
                end else begin
                    return close_pair(b, 16'd1, r);
                end
            end
            PH_LEN8: begin
                if (b == 8'd0) begin
                    phase = PH_LEN16_LO;
                end else begin
                    run_len = {8'd0, b};
                    phase   = PH_RUNVAL;
                end
            end
            PH_LEN16_LO: begin
                hold  = b;
                phase = PH_LEN16_HI;
            end
            PH_LEN16_HI: begin
                run_len = {b, hold};
                phase   = PH_RUNVAL;
            end
            PH_RUNVAL: begin
                // zero-length run swallows its value byte and gives nothing
                if (run_len == 16'd0) begin
                    phase = PH_DATA;
                end else begin
                    return close_pair(b, run_len, r);
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function void note_byte(input logic [7:0] b);
        t_result r;
        if (parse_byte(b, r)) pairs_due.push_back(r);
    endfunction

    function int pending();
        return pairs_due.size();
    endfunction

    function void cmp_field(input string name, input int unsigned want,
                            input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    function void check_pair(input t_result got);
        t_result want;
        if (pairs_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual value %0d count %0d",
                     $time, got.value, got.count);
            return;
        end
        want = pairs_due.pop_front();
        pairs_checked++;
        if (want.block_end) blocks_closed++;
        if (want.size_error) overshoots++;
        if (want.image_done) images_done++;
        cmp_field("out_value", want.value, got.value);
        cmp_field("out_count", want.count, got.count);
        cmp_field("block_end", want.block_end, got.block_end);
        cmp_field("size_error", want.size_error, got.size_error);
        cmp_field("image_done", want.image_done, got.image_done);
    endfunction
endclass

module marker_rle_block_decoder_tb;

    localparam int TARGET_BYTES = 700;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_in_byte   = 8'd0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_out_value;
    logic [15:0] o_out_count;
    logic        o_block_end;
    logic        o_size_error;
    logic        o_image_done;

    pair_scoreboard sb;
    pair_scoreboard planner;
    logic [7:0]     stream_q[$];
    logic [7:0]     directed_bytes [0:29];
    t_result        seen_pair;
    int             bytes_taken = 0;
    bit             quiet = 1'b0;

    marker_rle_block_decoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_value  (o_out_value),
        .o_out_count  (o_out_count),
        .o_block_end  (o_block_end),
        .o_size_error (o_size_error),
        .o_image_done (o_image_done)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    // both transaction sides sampled with pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                seen_pair            = '0;
                seen_pair.valid      = 1'b1;
                seen_pair.value      = o_out_value;
                seen_pair.count      = o_out_count;
                seen_pair.block_end  = o_block_end;
                seen_pair.size_error = o_size_error;
                seen_pair.image_done = o_image_done;
                sb.check_pair(seen_pair);
            end
            if (i_in_valid && o_in_ready === 1'b1) begin
                sb.note_byte(i_in_byte);
                bytes_taken++;
            end
        end
    end

    function automatic int idle_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void put(input logic [7:0] b);
        t_result unused;
        void'(planner.parse_byte(b, unused));
        stream_q.push_back(b);
    endfunction

    // byte stream steered by a shadow parser so most blocks are well formed
    task automatic build_stream();
        int nblk;
        int per_blk;
        int next_size;
        int run16;
        int remaining;
        int r;
        logic [7:0] b;
        planner = new();
        nblk = $urandom_range(45, 60);
        put(nblk[7:0]);
        put(nblk[15:8]);
        // zero size block; full size block with a zero-length run then an
        // exact fill; small block ending in an overshooting run
        directed_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF,
                           8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
                           8'hFF, 8'h00, 8'h00, 8'h00, 8'h5A,
                           8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00,
                           8'h12, 8'h34, 8'h03, 8'h00, 8'h80,
                           8'h00, 8'h80, 8'hFF, 8'h01};
        foreach (directed_bytes[i]) put(directed_bytes[i]);
        next_size = 0;
        run16 = 0;
        while (planner.phase != PH_DONE) begin
            remaining = int'(planner.block_size) - int'(planner.filled);
            r = $urandom_range(0, 99);
            case (planner.phase)
                PH_USZ_LO: begin
                    per_blk = (TARGET_BYTES - stream_q.size()) /
                              int'(planner.blocks_left);
                    if (per_blk < 4) per_blk = 4;
                    if (r < 4) next_size = 0;
                    else if (r < 8) next_size = $urandom_range(256, 65535);
                    else next_size = $urandom_range(1, per_blk);
                    put(next_size[7:0]);
                end
                PH_USZ_HI: put(next_size[15:8]);
                PH_DATA: begin
                    if (r < 5) begin
                        put(8'($urandom_range(0, 255)));
                    end else if (r < 60) begin
                        do b = 8'($urandom_range(0, 255)); while (b == planner.marker);
                        put(b);
                    end else begin
                        put(planner.marker);
                    end
                end
                PH_LEN8: begin
                    if (r < 15 || remaining > 1000) put(8'd0);
                    else if (r < 60) put(8'($urandom_range(1, 8)));
                    else put(8'($urandom_range(1, 255)));
                end
                PH_LEN16_LO: begin
                    if (r < 15) run16 = 0;
                    else if (r < 25) run16 = 65535;
                    else run16 = $urandom_range(1, (remaining + 16 > 65535) ?
                                                    65535 : remaining + 16);
                    put(run16[7:0]);
                end
                PH_LEN16_HI: put(run16[15:8]);
                default: put(8'($urandom_range(0, 255)));
            endcase
        end
        // trailing bytes after the last block must be swallowed silently
        repeat (8) put(8'($urandom_range(0, 255)));
    endtask

    task automatic send_stream();
        int gap;
        for (int idx = 0; idx < stream_q.size(); idx++) begin
            if (idx % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
            gap = idle_gap();
            if (idx == stream_q.size() / 2) begin
                // hold off until the decoder has drained every pair
                @(negedge i_clk) i_in_valid <= 1'b0;
                while (sb.pending() != 0) @(negedge i_clk);
            end else if (gap > 0) begin
                @(negedge i_clk) i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_in_valid <= 1'b1;
            i_in_byte  <= stream_q[idx];
            do @(posedge i_clk); while (o_in_ready !== 1'b1);
        end
        @(negedge i_clk) i_in_valid <= 1'b0;
    endtask

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = idle_gap();
            if (gap > 0) begin
                @(negedge i_clk) i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk) i_out_ready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    end

    initial begin
        sb = new();
        build_stream();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_stream();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("decoded %0d stream bytes into %0d checked pairs", bytes_taken,
                 sb.pairs_checked);
        $display("%0d blocks closed, %0d with overshoot, image completions seen: %0d",
                 sb.blocks_closed, sb.overshoots, sb.images_done);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
design/mrbd_pkg.sv
design/mrbd_parser.sv
design/marker_rle_block_decoder.sv
tb/sv/marker_rle_block_decoder_tb.sv
